// File: rtl/kmd_pkg.sv
package kmd_pkg;

  localparam int ROWS_DEF     = 5;
  localparam int COLS_DEF     = 14;
  localparam int MAX_KEYS_DEF = 6;
  localparam int LAYERS_DEF   = 3;

  localparam int ROW_W  = 3;
  localparam int COL_W  = 14;
  localparam int POS_W  = 7;
  localparam int CODE_W = 8;
  localparam int SLOTS  = 6;

  localparam logic [3:0] DEBOUNCE_RST = 4'd5;
  localparam logic [7:0] CLEAN_RST    = 8'd41;
  localparam logic [7:0] LAYER1_RST   = 8'd135;
  localparam logic [7:0] LAYER2_RST   = 8'd136;
  localparam logic [7:0] MOD_BASE     = 8'd224;

  // configuration register indexes
  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_CLEAN    = 2'd1;
  localparam logic [1:0] REG_LAYER1   = 2'd2;
  localparam logic [1:0] REG_LAYER2   = 2'd3;

  typedef struct packed {
    logic [ROW_W-1:0] row_index;
    logic [COL_W-1:0] column_levels;
  } in_item_t;

  typedef struct packed {
    logic [7:0] modifiers;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;
    logic [1:0] layer_used;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load_row;      // store row sample, update debounce
    logic collect_start; // clear pressing list, start scan walk
    logic collect_step;  // examine one matrix position
    logic new_step;      // examine pressing[idx] against held list
    logic old_step;      // examine held[idx] against pressing list
    logic commit_held;   // copy next list into held list
    logic mod_step;      // split next[idx] into mods / send
    logic report;        // run report rules, update sent state
    logic emit;          // latch output item
    logic [2:0] idx;
  } kmd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic accept;   // debounce hit zero on this scan end
    logic walk_done;
    logic [2:0] np;
    logic [2:0] nn;
    logic [2:0] held_n;
    logic changes;
    logic send_out; // report differs
  } kmd_stat_t;

  // layer 0..2 keymap, position = row*14+col
  function automatic logic [7:0] rom_code(input logic [1:0] layer, input logic [6:0] pos);
    logic [7:0] c;
    c = 8'd0;
    unique case (pos)
      7'd0: c = 8'd41;
      7'd1: c = (layer == 2'd1) ? 8'd58 : 8'd30;
      7'd2: c = (layer == 2'd1) ? 8'd59 : 8'd31;
      7'd3: c = (layer == 2'd1) ? 8'd60 : 8'd32;
      7'd4: c = (layer == 2'd1) ? 8'd61 : 8'd33;
      7'd5: c = (layer == 2'd1) ? 8'd62 : 8'd34;
      7'd6: c = (layer == 2'd1) ? 8'd63 : 8'd35;
      7'd7: c = (layer == 2'd1) ? 8'd64 : 8'd36;
      7'd8: c = (layer == 2'd1) ? 8'd65 : 8'd37;
      7'd9: c = (layer == 2'd1) ? 8'd66 : 8'd38;
      7'd10: c = (layer == 2'd1) ? 8'd67 : 8'd39;
      7'd11: c = (layer == 2'd1) ? 8'd68 : 8'd45;
      7'd12: c = (layer == 2'd1) ? 8'd69 : 8'd46;
      7'd13: c = 8'd42;
      7'd14: c = 8'd43;
      7'd15: c = 8'd20;
      7'd16: c = 8'd26;
      7'd17: c = 8'd8;
      7'd18: c = 8'd21;
      7'd19: c = 8'd23;
      7'd20: c = 8'd28;
      7'd21: c = 8'd24;
      7'd22: c = (layer == 2'd2) ? 8'd82 : 8'd12;
      7'd23: c = 8'd18;
      7'd24: c = 8'd19;
      7'd25: c = 8'd47;
      7'd26: c = 8'd48;
      7'd27: c = 8'd49;
      7'd28: c = 8'd57;
      7'd29: c = 8'd4;
      7'd30: c = 8'd22;
      7'd31: c = 8'd7;
      7'd32: c = 8'd9;
      7'd33: c = 8'd10;
      7'd34: c = 8'd11;
      7'd35: c = (layer == 2'd2) ? 8'd80 : 8'd13;
      7'd36: c = (layer == 2'd2) ? 8'd81 : 8'd14;
      7'd37: c = (layer == 2'd2) ? 8'd79 : 8'd15;
      7'd38: c = 8'd51;
      7'd39: c = 8'd52;
      7'd40: c = 8'd40;
      7'd41: c = 8'd40;
      7'd42: c = 8'd225;
      7'd43: c = 8'd225;
      7'd44: c = 8'd29;
      7'd45: c = 8'd27;
      7'd46: c = 8'd6;
      7'd47: c = 8'd25;
      7'd48: c = 8'd5;
      7'd49: c = 8'd17;
      7'd50: c = 8'd16;
      7'd51: c = 8'd54;
      7'd52: c = 8'd55;
      7'd53: c = 8'd56;
      7'd54: c = 8'd0;
      7'd55: c = 8'd229;
      7'd56: c = 8'd224;
      7'd57: c = 8'd227;
      7'd58: c = 8'd82;
      7'd59: c = 8'd226;
      7'd60: c = 8'd44;
      7'd61: c = 8'd44;
      7'd62: c = 8'd44;
      7'd63: c = 8'd44;
      7'd64: c = 8'd228;
      7'd65: c = 8'd80;
      7'd66: c = 8'd79;
      7'd67: c = 8'd80;
      7'd68: c = (layer == 2'd0) ? 8'd135 : 8'd0;
      7'd69: c = (layer == 2'd0) ? 8'd136 : 8'd0;
      default: c = 8'd0;
    endcase
    if (layer == 2'd3) c = 8'd0;
    return c;
  endfunction

endpackage

// File: rtl/kmd_ctrl.sv
module kmd_ctrl
  import kmd_pkg::*;
#(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      in_last_row,
  input  logic      out_busy,
  input  kmd_stat_t stat,
  output kmd_cmd_t  cmd,
  output logic      idle
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CHECK   = 4'd1;
  localparam logic [3:0] S_WSTART  = 4'd2;
  localparam logic [3:0] S_WALK    = 4'd3;
  localparam logic [3:0] S_NEW     = 4'd4;
  localparam logic [3:0] S_OLD     = 4'd5;
  localparam logic [3:0] S_COMMIT  = 4'd6;
  localparam logic [3:0] S_MODS    = 4'd7;
  localparam logic [3:0] S_REPORT  = 4'd8;
  localparam logic [3:0] S_EMIT    = 4'd9;

  logic [3:0] state, state_next;
  logic [2:0] idx, idx_next;
  logic       last, last_next;

  assign idle = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      last  <= last_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    idx_next   = idx;
    last_next  = last;
    cmd        = '0;
    cmd.idx    = idx;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_row = 1'b1;
          last_next    = in_last_row;
          state_next   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (last && stat.accept) state_next = S_WSTART;
        else state_next = S_IDLE;
      end
      S_WSTART: begin
        cmd.collect_start = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        cmd.collect_step = 1'b1;
        if (stat.walk_done) begin
          idx_next   = '0;
          state_next = S_NEW;
        end
      end
      S_NEW: begin
        if (idx >= stat.np) begin
          idx_next   = '0;
          state_next = S_OLD;
        end else begin
          cmd.new_step = 1'b1;
          idx_next     = idx + 3'd1;
        end
      end
      S_OLD: begin
        if (idx >= stat.held_n) begin
          state_next = S_COMMIT;
        end else begin
          cmd.old_step = 1'b1;
          idx_next     = idx + 3'd1;
        end
      end
      S_COMMIT: begin
        cmd.commit_held = 1'b1;
        idx_next   = '0;
        state_next = S_MODS;
      end
      S_MODS: begin
        if (idx >= stat.nn) begin
          state_next = stat.changes ? S_REPORT : S_IDLE;
        end else begin
          cmd.mod_step = 1'b1;
          idx_next     = idx + 3'd1;
        end
      end
      S_REPORT: begin
        cmd.report = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.send_out) begin
          state_next = S_IDLE;
        end else if (!out_busy) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  a_emit_only_in_emit: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (state == S_EMIT) && !out_busy)
    else $error("emit outside emit state");
  a_walk_follows_start: assert property (@(posedge clk) disable iff (rst)
    cmd.collect_start |=> state == S_WALK)
    else $error("walk did not follow start");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.new_step |-> idx < MAX_KEYS)
    else $error("pressing index out of range");
  a_load_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load_row |=> state == S_CHECK)
    else $error("row load without check");

endmodule

// File: rtl/kmd_datapath.sv
module kmd_datapath
  import kmd_pkg::*;
#(
  parameter int ROWS     = ROWS_DEF,
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int LAYERS   = LAYERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_item,
  input  logic [3:0] debounce_scans,
  input  logic [7:0] clean_key_code,
  input  logic [7:0] layer1_key_code,
  input  logic [7:0] layer2_key_code,
  input  kmd_cmd_t   cmd,
  output kmd_stat_t  stat,
  output out_item_t  result
);

  // keymap positions are row*14+col, so the column count is fixed
  localparam int COLS = COLS_DEF;
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [COL_W-1:0] COL_MASK = COL_W'((32'd1 << COLS) - 32'd1);

  logic [COL_W-1:0] row_samples [ROWS];
  logic [3:0]       debounce_count;
  logic             accept;
  logic [POS_W-1:0] held [MAX_KEYS];
  logic [2:0]       held_n;
  logic [POS_W-1:0] pressing [MAX_KEYS];
  logic [2:0]       np;
  logic [POS_W-1:0] nxt [MAX_KEYS];
  logic [2:0]       nn;
  logic [POS_W-1:0] send [MAX_KEYS];
  logic [2:0]       ns;
  logic [7:0]       mods;
  logic             changes;
  logic [POS_W-1:0] sent [MAX_KEYS];
  logic [2:0]       sent_n;
  logic [7:0]       sent_mods;
  logic [1:0]       layer_mode;
  logic             clean_en;
  logic             first_pend;
  logic             send_out;
  logic [RW-1:0]    wr;
  logic [CW-1:0]    wc;
  logic [POS_W-1:0] wpos;
  logic             walk_done;

  // row capture index and pressed bits
  logic [RW-1:0]    in_row;
  logic             in_row_ok;
  logic [COL_W-1:0] pressed;
  assign in_row    = in_item.row_index[RW-1:0];
  assign in_row_ok = (32'(in_item.row_index) < ROWS);
  assign pressed   = ~in_item.column_levels & COL_MASK;

  // scan walk position bit
  logic wbit, wlast_pos;
  assign wbit      = row_samples[wr][wc];
  assign wlast_pos = (32'(wr) == ROWS - 1) && (32'(wc) == COLS - 1);
  assign walk_done = wlast_pos || (wbit && (32'(np) == MAX_KEYS - 1));

  // membership tests for the list steps
  logic [POS_W-1:0] cur_p, cur_h, cur_n;
  logic             p_in_held, h_in_press;
  logic [7:0]       cur_code;
  assign cur_p = pressing[cmd.idx[2:0]];
  assign cur_h = held[cmd.idx[2:0]];
  assign cur_n = nxt[cmd.idx[2:0]];
  assign cur_code = rom_code(2'd0, cur_n);

  always_comb begin
    p_in_held  = 1'b0;
    h_in_press = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if ((3'(i) < held_n) && (held[i] == cur_p)) p_in_held = 1'b1;
      if ((3'(i) < np) && (pressing[i] == cur_h)) h_in_press = 1'b1;
    end
  end

  // report rule lookups over send list
  logic has_clean, has_l1, has_l2, list_diff;
  always_comb begin
    has_clean = 1'b0;
    has_l1    = 1'b0;
    has_l2    = 1'b0;
    list_diff = 1'b0;
    for (int i = 0; i < MAX_KEYS; i++) begin
      if (3'(i) < ns) begin
        if (rom_code(2'd0, send[i]) == clean_key_code)  has_clean = 1'b1;
        if (rom_code(2'd0, send[i]) == layer1_key_code) has_l1    = 1'b1;
        if (rom_code(2'd0, send[i]) == layer2_key_code) has_l2    = 1'b1;
        if (sent[i] != send[i]) list_diff = 1'b1;
      end
    end
  end

  logic [1:0] lm_a, lm_b;
  logic       clean_eff;
  always_comb begin
    clean_eff = first_pend ? has_clean : clean_en;
    lm_a      = (layer_mode == 2'd2) ? 2'd2 : 2'd0;
    if (clean_eff && has_l1) lm_a = 2'd1;
    lm_b = lm_a;
    if (clean_eff && has_l2) lm_b = (lm_a == 2'd0) ? 2'd2 : 2'd0;
  end

  function automatic logic [7:0] xlate(input logic [1:0] l, input logic [POS_W-1:0] p);
    return (32'(l) < LAYERS) ? rom_code(l, p) : 8'd0;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ROWS; i++) row_samples[i] <= '0;
      for (int i = 0; i < MAX_KEYS; i++) sent[i] <= '0;
      debounce_count <= DEBOUNCE_RST;
      accept     <= 1'b0;
      held_n     <= '0;
      sent_n     <= '0;
      sent_mods  <= '0;
      layer_mode <= '0;
      clean_en   <= 1'b0;
      first_pend <= 1'b1;
      send_out   <= 1'b0;
      np <= '0; nn <= '0; ns <= '0; mods <= '0; changes <= 1'b0;
      wr <= '0; wc <= '0; wpos <= '0;
    end else begin
      // row sample and debounce
      if (cmd.load_row) begin
        logic [3:0] cnt;
        cnt    = debounce_count;
        accept <= 1'b0;
        if (in_row_ok) begin
          if (pressed != row_samples[in_row]) begin
            row_samples[in_row] <= pressed;
            cnt = debounce_scans;
          end
          if (32'(in_item.row_index) == ROWS - 1 && cnt != 4'd0) begin
            cnt = cnt - 4'd1;
            accept <= (cnt == 4'd0);
          end
        end
        debounce_count <= cnt;
      end
      // scan walk
      if (cmd.collect_start) begin
        np <= '0; nn <= '0; ns <= '0; mods <= '0; changes <= 1'b0;
        wr <= '0; wc <= '0; wpos <= '0;
      end
      if (cmd.collect_step) begin
        if (wbit) begin
          pressing[np] <= wpos;
          np <= np + 3'd1;
        end
        wpos <= wpos + 7'd1;
        if (32'(wc) == COLS - 1) begin
          wc <= '0;
          wr <= wr + 1'b1;
        end else begin
          wc <= wc + 1'b1;
        end
      end
      // new keys first
      if (cmd.new_step && !p_in_held) begin
        changes <= 1'b1;
        nxt[nn] <= cur_p;
        nn <= nn + 3'd1;
      end
      // then held keys in old order
      if (cmd.old_step) begin
        if (!h_in_press) changes <= 1'b1;
        else if (32'(nn) < MAX_KEYS) begin
          nxt[nn] <= cur_h;
          nn <= nn + 3'd1;
        end
      end
      if (cmd.commit_held) begin
        for (int i = 0; i < MAX_KEYS; i++) held[i] <= nxt[i];
        held_n <= nn;
      end
      // modifier split
      if (cmd.mod_step) begin
        if (cur_code >= MOD_BASE) mods <= mods | (8'd1 << cur_code[2:0]);
        else begin
          send[ns] <= cur_n;
          ns <= ns + 3'd1;
        end
      end
      // report rules
      if (cmd.report) begin
        send_out   <= (sent_n != ns) || (sent_mods != mods) || list_diff;
        first_pend <= 1'b0;
        clean_en   <= clean_eff;
        layer_mode <= ((sent_n != ns) || (sent_mods != mods) || list_diff) ? lm_b : lm_a;
        for (int i = 0; i < MAX_KEYS; i++) if (3'(i) < ns) sent[i] <= send[i];
        sent_n    <= ns;
        sent_mods <= mods;
      end
      if (cmd.emit) begin
        result.modifiers  <= mods;
        result.key_slot_0 <= (ns > 3'd0) ? xlate(layer_mode, send[0]) : 8'd0;
        result.key_slot_1 <= (ns > 3'd1 && MAX_KEYS > 1) ? xlate(layer_mode, send[1]) : 8'd0;
        result.key_slot_2 <= (ns > 3'd2 && MAX_KEYS > 2) ? xlate(layer_mode, send[2]) : 8'd0;
        result.key_slot_3 <= (ns > 3'd3 && MAX_KEYS > 3) ? xlate(layer_mode, send[3]) : 8'd0;
        result.key_slot_4 <= (ns > 3'd4 && MAX_KEYS > 4) ? xlate(layer_mode, send[4]) : 8'd0;
        result.key_slot_5 <= (ns > 3'd5 && MAX_KEYS > 5) ? xlate(layer_mode, send[5]) : 8'd0;
        result.layer_used <= layer_mode;
      end
    end
  end

  assign stat.accept    = accept;
  assign stat.walk_done = walk_done;
  assign stat.np        = np;
  assign stat.nn        = nn;
  assign stat.held_n    = held_n;
  assign stat.changes   = changes;
  assign stat.send_out  = send_out;

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (32'(np) <= MAX_KEYS) && (32'(nn) <= MAX_KEYS) && (32'(held_n) <= MAX_KEYS))
    else $error("list count overflow");
  a_ns_le_nn: assert property (@(posedge clk) disable iff (rst)
    ns <= nn)
    else $error("send list longer than key list");
  a_layer_valid: assert property (@(posedge clk) disable iff (rst)
    layer_mode != 2'd3)
    else $error("bad layer mode");

endmodule

// File: rtl/key_matrix_debounce_hid_report_top.sv
// Channel | Direction | Handshake       | Payload
// in      | input     | in_valid/stall  | in_item (row_index, column_levels)
// out     | output    | out_valid/stall | out_item (modifiers, key slots, layer)
// cfg     | input     | cfg_valid/ready | cfg_index, cfg_data
// A row that does not end a scan, or an ending scan that is not accepted, goes through S_CHECK back to idle.
// An accepted scan then runs the one-position-per-cycle matrix walk and the list walks
// before any report is emitted; in_stall stays high until the controller is idle again.
// rst is synchronous and active high; all state but the working key lists and out_item returns to power-up values.
// A finished report sits in the output register; a new row is taken while it waits,
// and only the next report waits for the output register to drain.
module key_matrix_debounce_hid_report_top
  import kmd_pkg::*;
#(
  parameter int ROWS     = ROWS_DEF,
  parameter int MAX_KEYS = MAX_KEYS_DEF,
  parameter int LAYERS   = LAYERS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic [3:0] debounce_scans;
  logic [7:0] clean_key_code, layer1_key_code, layer2_key_code;
  kmd_cmd_t   cmd;
  kmd_stat_t  stat;
  logic       idle, in_fire;

  assign cfg_ready = 1'b1;
  assign in_stall  = !idle;
  assign in_fire   = in_valid && idle;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans  <= DEBOUNCE_RST;
      clean_key_code  <= CLEAN_RST;
      layer1_key_code <= LAYER1_RST;
      layer2_key_code <= LAYER2_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE: debounce_scans  <= cfg_data[3:0];
        REG_CLEAN:    clean_key_code  <= cfg_data;
        REG_LAYER1:   layer1_key_code <= cfg_data;
        REG_LAYER2:   layer2_key_code <= cfg_data;
        default: ;
      endcase
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  kmd_ctrl #(.MAX_KEYS(MAX_KEYS)) u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire),
    .in_last_row(32'(in_item.row_index) == ROWS - 1),
    .out_busy(out_valid && out_stall), .stat(stat), .cmd(cmd), .idle(idle)
  );

  kmd_datapath #(.ROWS(ROWS), .MAX_KEYS(MAX_KEYS), .LAYERS(LAYERS)) u_dp (
    .clk(clk), .rst(rst), .in_item(in_item),
    .debounce_scans(debounce_scans), .clean_key_code(clean_key_code),
    .layer1_key_code(layer1_key_code), .layer2_key_code(layer2_key_code),
    .cmd(cmd), .stat(stat), .result(out_item)
  );

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.emit)
    else $error("output overwritten while stalled");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emit without valid");
  a_fire_idle: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !idle)
    else $error("item taken while busy");

endmodule

// File: bench/tb_key_matrix_debounce_hid_report_top.sv
module tb_key_matrix_debounce_hid_report_top;
  import kmd_pkg::*;

  localparam int NROWS = 5;
  localparam int NCOLS = 14;
  localparam int NPOS = NROWS * NCOLS;
  localparam int NKEYS = 6;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int SETTLE_CYCLES = 150;
  localparam int LONG_HOLD = 400;

  // layer 0 keymap, position = row*14+col
  localparam logic [7:0] BASE_MAP [NPOS] = '{
    41, 30, 31, 32, 33, 34, 35, 36, 37, 38, 39, 45, 46, 42,
    43, 20, 26, 8, 21, 23, 28, 24, 12, 18, 19, 47, 48, 49,
    57, 4, 22, 7, 9, 10, 11, 13, 14, 15, 51, 52, 40, 40,
    225, 225, 29, 27, 6, 25, 5, 17, 16, 54, 55, 56, 0, 229,
    224, 227, 82, 226, 44, 44, 44, 44, 228, 80, 79, 80, 135, 136};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_DEBOUNCE;
  logic [7:0] cfg_data = '0;

  key_matrix_debounce_hid_report_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state and register copies
  logic [3:0] cfg_debounce = DEBOUNCE_RST;
  logic [7:0] cfg_clean = CLEAN_RST;
  logic [7:0] cfg_layer1 = LAYER1_RST;
  logic [7:0] cfg_layer2 = LAYER2_RST;
  logic [13:0] row_seen [NROWS];
  logic [3:0] db_count = DEBOUNCE_RST;
  logic [6:0] held_pos [NKEYS];
  int held_n = 0;
  logic [6:0] sent_pos [NKEYS];
  int sent_n = 0;
  logic [7:0] sent_mods = '0;
  logic [1:0] layer_sel = '0;
  bit clean_on = 1'b0;
  bit first_pending = 1'b1;

  out_item_t pending_reports [$];
  int errors = 0;
  int cycles = 0;
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;
  int items_sent = 0;
  bit keys_down [NPOS];

  function automatic logic [7:0] key_code(int layer, int pos);
    logic [7:0] c;
    if (layer >= 3 || pos >= NPOS) return 8'd0;
    c = BASE_MAP[pos];
    if (layer == 1) begin
      if (pos >= 1 && pos <= 12) c = 8'(57 + pos);
      if (pos >= 68) c = 8'd0;
    end else if (layer == 2) begin
      case (pos)
        22: c = 8'd82;
        35: c = 8'd80;
        36: c = 8'd81;
        37: c = 8'd79;
        68, 69: c = 8'd0;
        default: ;
      endcase
    end
    return c;
  endfunction

  function automatic bit has_pos(logic [6:0] list [NKEYS], int n, logic [6:0] p);
    for (int i = 0; i < n; i++) if (list[i] == p) return 1'b1;
    return 1'b0;
  endfunction

  function automatic bit has_code(logic [6:0] list [NKEYS], int n, logic [7:0] code);
    for (int i = 0; i < n; i++) if (key_code(0, list[i]) == code) return 1'b1;
    return 1'b0;
  endfunction

  // advance the scanner state by one accepted row, queue any report
  task automatic predict_row(in_item_t it);
    logic [6:0] pressing [NKEYS];
    logic [6:0] nxt [NKEYS];
    logic [6:0] snd [NKEYS];
    logic [7:0] slots [NKEYS];
    logic [13:0] pr;
    logic [7:0] mods;
    logic [7:0] code;
    int np, nn, ns;
    bit changes, differs;
    out_item_t o;
    np = 0; nn = 0; ns = 0; changes = 0; mods = '0;
    if (it.row_index >= NROWS) return;
    pr = ~it.column_levels;
    if (pr != row_seen[it.row_index]) begin
      row_seen[it.row_index] = pr;
      db_count = cfg_debounce;
    end
    if (it.row_index != NROWS - 1) return;
    if (db_count == 0) return;
    db_count--;
    if (db_count != 0) return;
    // scan-order walk
    for (int r = 0; r < NROWS; r++)
      for (int c = 0; c < NCOLS; c++)
        if (np < NKEYS && row_seen[r][c]) begin
          pressing[np] = 7'(r * NCOLS + c);
          np++;
        end
    // new keys first, then keys still held
    for (int i = 0; i < np; i++)
      if (!has_pos(held_pos, held_n, pressing[i])) begin
        changes = 1;
        nxt[nn] = pressing[i];
        nn++;
      end
    for (int i = 0; i < held_n; i++) begin
      if (!has_pos(pressing, np, held_pos[i])) changes = 1;
      else if (nn < NKEYS) begin
        nxt[nn] = held_pos[i];
        nn++;
      end
    end
    for (int i = 0; i < nn; i++) held_pos[i] = nxt[i];
    held_n = nn;
    for (int i = 0; i < nn; i++) begin
      code = key_code(0, nxt[i]);
      if (code >= MOD_BASE) mods[code - MOD_BASE] = 1'b1;
      else begin
        snd[ns] = nxt[i];
        ns++;
      end
    end
    if (!changes) return;
    // report rules
    differs = (sent_n != ns) || (sent_mods != mods);
    if (layer_sel != 2'd2) layer_sel = 2'd0;
    if (first_pending) begin
      first_pending = 0;
      clean_on = has_code(snd, ns, cfg_clean);
    end
    if (clean_on && has_code(snd, ns, cfg_layer1)) layer_sel = 2'd1;
    for (int i = 0; i < ns; i++)
      if (sent_pos[i] != snd[i]) begin
        differs = 1;
        sent_pos[i] = snd[i];
      end
    sent_n = ns;
    sent_mods = mods;
    if (!differs) return;
    if (clean_on && has_code(snd, ns, cfg_layer2)) layer_sel = (layer_sel == 0) ? 2'd2 : 2'd0;
    for (int i = 0; i < NKEYS; i++) slots[i] = (i < ns) ? key_code(layer_sel, snd[i]) : 8'd0;
    o.modifiers = mods;
    o.key_slot_0 = slots[0];
    o.key_slot_1 = slots[1];
    o.key_slot_2 = slots[2];
    o.key_slot_3 = slots[3];
    o.key_slot_4 = slots[4];
    o.key_slot_5 = slots[5];
    o.layer_used = layer_sel;
    pending_reports.push_back(o);
  endtask

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic check_field(string what, logic [7:0] got, logic [7:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // report checker
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_reports.size() == 0) report_mismatch("unexpected report", out_item.modifiers, 8'd0);
      else begin
        want = pending_reports.pop_front();
        check_field("modifiers", out_item.modifiers, want.modifiers);
        check_field("key_slot_0", out_item.key_slot_0, want.key_slot_0);
        check_field("key_slot_1", out_item.key_slot_1, want.key_slot_1);
        check_field("key_slot_2", out_item.key_slot_2, want.key_slot_2);
        check_field("key_slot_3", out_item.key_slot_3, want.key_slot_3);
        check_field("key_slot_4", out_item.key_slot_4, want.key_slot_4);
        check_field("key_slot_5", out_item.key_slot_5, want.key_slot_5);
        check_field("layer_used", 8'(out_item.layer_used), 8'(want.layer_used));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // report receiver: random stall per item, one long hold on request
  initial begin
    int w;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      w = idle_on ? $urandom_range(0, 13) : 0;
      if (hold_req) begin
        hold_req = 0;
        w = LONG_HOLD;
      end
      if (w > 0) begin
        out_stall <= 1'b1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  // one row item; valid stays high until the next call or park_input
  task automatic send_row(int row, logic [13:0] levels);
    int gap;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{row_index: 3'(row), column_levels: levels};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_row(in_item);
    items_sent++;
  endtask

  task automatic park_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_reports();
    park_input();
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    drain_reports();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_DEBOUNCE: cfg_debounce = val[3:0];
      REG_CLEAN: cfg_clean = val;
      REG_LAYER1: cfg_layer1 = val;
      REG_LAYER2: cfg_layer2 = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [13:0] row_levels(int r);
    logic [13:0] lv;
    for (int c = 0; c < NCOLS; c++) lv[c] = ~keys_down[r * NCOLS + c];
    return lv;
  endfunction

  // full scan of the current key set, with optional stray items
  task automatic send_scan(bit noisy);
    for (int r = 0; r < NROWS; r++) begin
      if (noisy && $urandom_range(0, 19) == 0)
        send_row($urandom_range(0, 7), 14'($urandom));
      send_row(r, row_levels(r));
    end
  endtask

  task automatic set_keys(int a, int b = -1, int c = -1);
    foreach (keys_down[i]) keys_down[i] = 0;
    if (a >= 0) keys_down[a] = 1;
    if (b >= 0) keys_down[b] = 1;
    if (c >= 0) keys_down[c] = 1;
  endtask

  // clean mode, layer keys, modifiers, overflow, release, ignored row
  task automatic test_directed();
    write_reg(REG_DEBOUNCE, 8'd1);
    set_keys(0, 42, 56);
    send_scan(0);
    set_keys(0, 68, 15);
    send_scan(0);
    for (int r = 0; r < NROWS; r++) send_row(r, 14'h0000);
    set_keys(69, 22, 59);
    send_scan(0);
    send_row(7, 14'h0000);
    for (int r = 0; r < NROWS; r++) send_row(r, 14'h3fff);
  endtask

  // zero debounce: nothing accepted
  task automatic test_zero_debounce();
    write_reg(REG_DEBOUNCE, 8'd0);
    for (int k = 0; k < 8; k++) begin
      set_keys($urandom_range(0, NPOS - 1));
      send_scan(1);
    end
  endtask

  // random key sets held for random scan counts
  task automatic test_random_phase(int deb, int budget, bit idle, bit long_hold);
    int pos, reps, stop_at;
    write_reg(REG_DEBOUNCE, 8'(deb));
    write_reg(REG_CLEAN, 8'($urandom));
    pos = $urandom_range(0, NPOS - 1);
    write_reg(REG_LAYER1, ($urandom_range(0, 3) == 0) ? 8'($urandom) : key_code(0, pos));
    pos = $urandom_range(0, NPOS - 1);
    write_reg(REG_LAYER2, ($urandom_range(0, 3) == 0) ? 8'($urandom) : key_code(0, pos));
    park_input();
    idle_on = idle;
    hold_req = long_hold;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      case ($urandom_range(0, 9))
        0: foreach (keys_down[i]) keys_down[i] = 0;
        1: for (int k = 0; k < 9; k++) keys_down[$urandom_range(0, NPOS - 1)] = 1;
        default: for (int k = $urandom_range(1, 3); k > 0; k--) begin
          pos = $urandom_range(0, NPOS - 1);
          keys_down[pos] = !keys_down[pos];
        end
      endcase
      reps = $urandom_range(1, deb + 1);
      for (int s = 0; s < reps; s++) send_scan(1);
      if ($urandom_range(0, 15) == 0) send_row($urandom_range(0, NROWS - 1), 14'($urandom));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    foreach (row_seen[i]) row_seen[i] = '0;
    foreach (held_pos[i]) held_pos[i] = '0;
    foreach (sent_pos[i]) sent_pos[i] = '0;
    foreach (keys_down[i]) keys_down[i] = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_zero_debounce();
    test_random_phase(1, 350, 1, 0);
    test_random_phase(2, 350, 0, 1);
    test_random_phase(15, 250, 1, 0);
    test_random_phase($urandom_range(1, 4), 350, 1, 0);
    test_random_phase(3, 300, 0, 0);
    test_random_phase(1, 350, 1, 0);
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/kmd_pkg.sv
rtl/kmd_ctrl.sv
rtl/kmd_datapath.sv
rtl/key_matrix_debounce_hid_report_top.sv
bench/tb_key_matrix_debounce_hid_report_top.sv
